FILE: sv/mzc_pkg.sv
`default_nettype none

package mzc_pkg;

  // Input item: one command to the carver
  typedef struct packed {
    logic        op;
    logic [15:0] random_value;
  } in_t;

  // Result item: one report per accepted item
  typedef struct packed {
    logic       carved;
    logic [2:0] from_x;
    logic [2:0] from_y;
    logic [1:0] direction;
    logic [2:0] to_x;
    logic [2:0] to_y;
    logic       done_res;
  } out_t;

  // Operation codes of the op field
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Passage directions, also the order in which neighbors are listed
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_rnd;  // capture the random word of an accepted item
    logic clr_init;   // rewind the visited-map clear sweep
    logic clr_row;    // clear one row of the visited map
    logic idle_emit;  // report an all-zero result
    logic rd_up;      // read the row above, keep the current row
    logic rd_dn;      // read the row below, keep the row above
    logic dec;        // carve, start a pop, or finish
    logic pop_load;   // move the walker to the popped cell
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic running;
    logic clr_last;
    logic has_nbr;
    logic stack_empty;
  } sts_t;

  // Remainder of a 16-bit word by three: 4 = 1 mod 3, so sum base-4 digits
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + {3'b000, v[2*i +: 2]};
    end
    // 16 = 1, 8 = 2, 4 = 1, 2 = 2 mod 3
    t = {2'b00, s[0]} + {1'b0, s[1], 1'b0} + {2'b00, s[2]} +
        {1'b0, s[3], 1'b0} + {2'b00, s[4]};
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/mzc_ctrl.sv
`default_nettype none

module mzc_ctrl
  import mzc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic op,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CLR  = 7'b0000010,
    S_RDC  = 7'b0000100,
    S_RDU  = 7'b0001000,
    S_RDD  = 7'b0010000,
    S_DEC  = 7'b0100000,
    S_POP  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Sequence one item through clear, row reads, decision and pop
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch_rnd = 1'b1;
          if (op == OP_START) begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLR;
          end else if (sts.running) begin
            state_nxt = S_RDC;
          end else begin
            cmd.idle_emit = 1'b1;
          end
        end
      end
      S_CLR: begin
        cmd.clr_row = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDC: begin
        state_nxt = S_RDU;
      end
      S_RDU: begin
        cmd.rd_up = 1'b1;
        state_nxt = S_RDD;
      end
      S_RDD: begin
        cmd.rd_dn = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        if (sts.has_nbr || sts.stack_empty) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

FILE: sv/mzc_dp.sv
`default_nettype none

module mzc_dp
  import mzc_pkg::*;
#(
  parameter int GRID_COLUMNS = 8,
  parameter int GRID_ROWS    = 6,
  parameter int STACK_DEPTH  = 48
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_item,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_t      out_item
);

  localparam int XW  = $clog2(GRID_COLUMNS);
  localparam int YW  = $clog2(GRID_ROWS);
  localparam int XEW = (XW > 3) ? XW : 3;
  localparam int YEW = (YW > 3) ? YW : 3;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SW  = XW + YW;

  // Visited map, one row of cells per word
  logic [GRID_COLUMNS-1:0] vis_mem [GRID_ROWS];
  logic [GRID_COLUMNS-1:0] rd_data_r;
  logic [YW-1:0]           vis_raddr;
  logic                    vis_we;
  logic [YW-1:0]           vis_waddr;
  logic [GRID_COLUMNS-1:0] vis_wdata;

  // Path stack, entries hold {y, x}
  logic [SW-1:0] stk_mem [STACK_DEPTH];
  logic [SW-1:0] stk_rd_r;
  logic [AW-1:0] stk_raddr;
  logic          stk_we;
  logic [CW-1:0] stk_cnt_r;
  logic [CW-1:0] cnt_m1;

  logic [XW-1:0]           x_r;
  logic [YW-1:0]           y_r;
  logic                    running_r;
  logic [YW-1:0]           clr_cnt_r;
  logic [GRID_COLUMNS-1:0] cur_row_r;
  logic [GRID_COLUMNS-1:0] up_row_r;
  logic [1:0]              rnd_lo_r;
  logic [1:0]              rnd_m3_r;
  logic                    out_valid_r;
  out_t                    out_item_r;

  logic                    clr_last;
  logic [XW-1:0]           xp1;
  logic [XW-1:0]           xm1;
  logic [YW-1:0]           yp1;
  logic [YW-1:0]           ym1;
  logic [YW-1:0]           up_addr;
  logic [YW-1:0]           dn_addr;
  logic [GRID_COLUMNS-1:0] sh_right;
  logic [GRID_COLUMNS-1:0] sh_left;
  logic [GRID_COLUMNS-1:0] sh_up;
  logic [GRID_COLUMNS-1:0] sh_dn;
  logic [3:0]              avail;
  logic [2:0]              nbr_cnt;
  logic [1:0]              pick;
  logic [1:0]              dir;
  logic [2:0]              seen;
  logic                    found;
  logic [XW-1:0]           tx;
  logic [YW-1:0]           ty;
  logic                    has_nbr;
  logic                    stack_empty;
  logic                    push_ok;

  function automatic logic [2:0] lo3x(input logic [XW-1:0] v);
    logic [XEW-1:0] e;
    e = XEW'(v);
    return e[2:0];
  endfunction

  function automatic logic [2:0] lo3y(input logic [YW-1:0] v);
    logic [YEW-1:0] e;
    e = YEW'(v);
    return e[2:0];
  endfunction

  // Neighbor coordinates, clamped read addresses at the grid border
  assign xp1      = x_r + XW'(1);
  assign xm1      = x_r - XW'(1);
  assign yp1      = y_r + YW'(1);
  assign ym1      = y_r - YW'(1);
  assign up_addr  = (y_r == '0) ? y_r : ym1;
  assign dn_addr  = (y_r == YW'(GRID_ROWS - 1)) ? y_r : yp1;
  assign clr_last = (clr_cnt_r == YW'(GRID_ROWS - 1));

  always_comb begin
    if (cmd.rd_up) begin
      vis_raddr = up_addr;
    end else if (cmd.rd_dn) begin
      vis_raddr = dn_addr;
    end else begin
      vis_raddr = y_r;
    end
  end

  // List unvisited neighbors; the row below is still on the read port
  assign sh_right = cur_row_r >> xp1;
  assign sh_left  = cur_row_r >> xm1;
  assign sh_up    = up_row_r >> x_r;
  assign sh_dn    = rd_data_r >> x_r;

  always_comb begin
    avail[DIR_RIGHT] = (x_r != XW'(GRID_COLUMNS - 1)) && !sh_right[0];
    avail[DIR_LEFT]  = (x_r != '0) && !sh_left[0];
    avail[DIR_UP]    = (y_r != '0) && !sh_up[0];
    avail[DIR_DOWN]  = (y_r != YW'(GRID_ROWS - 1)) && !sh_dn[0];
    nbr_cnt = 3'($countones(avail));
  end

  assign has_nbr = (nbr_cnt != 3'd0);

  // Reduce the random word by the neighbor count
  always_comb begin
    case (nbr_cnt)
      3'd2:    pick = {1'b0, rnd_lo_r[0]};
      3'd3:    pick = rnd_m3_r;
      3'd4:    pick = rnd_lo_r;
      default: pick = 2'd0;
    endcase
  end

  // Find the picked neighbor among the available ones
  always_comb begin
    dir   = DIR_RIGHT;
    seen  = 3'd0;
    found = 1'b0;
    for (int d = 0; d < 4; d++) begin
      if (avail[d]) begin
        if (!found && (seen == {1'b0, pick})) begin
          dir   = 2'(d);
          found = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  always_comb begin
    tx = x_r;
    ty = y_r;
    case (dir)
      DIR_RIGHT: tx = xp1;
      DIR_LEFT:  tx = xm1;
      DIR_UP:    ty = ym1;
      DIR_DOWN:  ty = yp1;
      default:   tx = x_r;
    endcase
  end

  // Visited map write: clear sweep, or mark the cell entered
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_cnt_r;
    vis_wdata = '0;
    if (cmd.clr_row) begin
      vis_we    = 1'b1;
      vis_wdata = (clr_cnt_r == '0) ? GRID_COLUMNS'(1) : '0;
    end else if (cmd.dec && has_nbr) begin
      vis_we    = 1'b1;
      vis_waddr = ty;
      case (dir)
        DIR_UP:   vis_wdata = up_row_r | (GRID_COLUMNS'(1) << tx);
        DIR_DOWN: vis_wdata = rd_data_r | (GRID_COLUMNS'(1) << tx);
        default:  vis_wdata = cur_row_r | (GRID_COLUMNS'(1) << tx);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    rd_data_r <= vis_mem[vis_raddr];
  end

  // Path stack: push on carve, read the top on backtrack
  assign stack_empty = (stk_cnt_r == '0);
  assign push_ok     = (stk_cnt_r < CW'(STACK_DEPTH));
  assign cnt_m1      = stk_cnt_r - CW'(1);
  assign stk_raddr   = cnt_m1[AW-1:0];
  assign stk_we      = cmd.dec && has_nbr && push_ok;

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_cnt_r[AW-1:0]] <= {y_r, x_r};
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  // Hold the row reads and the random word
  always_ff @(posedge clk) begin
    if (cmd.rd_up) begin
      cur_row_r <= rd_data_r;
    end
    if (cmd.rd_dn) begin
      up_row_r <= rd_data_r;
    end
    if (cmd.latch_rnd) begin
      rnd_lo_r <= in_item.random_value[1:0];
      rnd_m3_r <= mod3_16(in_item.random_value);
    end
  end

  // Walker, stack count, run flag and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      y_r         <= '0;
      running_r   <= 1'b0;
      stk_cnt_r   <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.clr_init) begin
        clr_cnt_r <= '0;
      end
      if (cmd.idle_emit) begin
        out_valid_r <= 1'b1;
        out_item_r  <= '0;
      end
      if (cmd.clr_row) begin
        clr_cnt_r <= clr_cnt_r + YW'(1);
        if (clr_last) begin
          x_r         <= '0;
          y_r         <= '0;
          stk_cnt_r   <= '0;
          running_r   <= 1'b1;
          out_valid_r <= 1'b1;
          out_item_r  <= '0;
        end
      end
      if (cmd.dec) begin
        if (has_nbr) begin
          if (push_ok) begin
            stk_cnt_r <= stk_cnt_r + CW'(1);
          end
          x_r                  <= tx;
          y_r                  <= ty;
          out_valid_r          <= 1'b1;
          out_item_r.carved    <= 1'b1;
          out_item_r.from_x    <= lo3x(x_r);
          out_item_r.from_y    <= lo3y(y_r);
          out_item_r.direction <= dir;
          out_item_r.to_x      <= lo3x(tx);
          out_item_r.to_y      <= lo3y(ty);
          out_item_r.done_res  <= 1'b0;
        end else if (!stack_empty) begin
          stk_cnt_r <= cnt_m1;
        end else begin
          running_r            <= 1'b0;
          out_valid_r          <= 1'b1;
          out_item_r.carved    <= 1'b0;
          out_item_r.from_x    <= lo3x(x_r);
          out_item_r.from_y    <= lo3y(y_r);
          out_item_r.direction <= DIR_RIGHT;
          out_item_r.to_x      <= lo3x(x_r);
          out_item_r.to_y      <= lo3y(y_r);
          out_item_r.done_res  <= 1'b1;
        end
      end
      if (cmd.pop_load) begin
        x_r                  <= stk_rd_r[XW-1:0];
        y_r                  <= stk_rd_r[SW-1:XW];
        out_valid_r          <= 1'b1;
        out_item_r.carved    <= 1'b0;
        out_item_r.from_x    <= lo3x(x_r);
        out_item_r.from_y    <= lo3y(y_r);
        out_item_r.direction <= DIR_RIGHT;
        out_item_r.to_x      <= lo3x(stk_rd_r[XW-1:0]);
        out_item_r.to_y      <= lo3y(stk_rd_r[SW-1:XW]);
        out_item_r.done_res  <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.running     = running_r;
    sts.clr_last    = clr_last;
    sts.has_nbr     = has_nbr;
    sts.stack_empty = stack_empty;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Stack count never passes the stack depth
  a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cnt_r <= CW'(STACK_DEPTH))
    else $error("path stack count beyond depth");

  // A search step is only decided while a maze is running
  a_dec_running: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec |-> running_r)
    else $error("search step decided while not running");

  // A done report leaves the carver idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.done_res) |-> !running_r)
    else $error("done reported while still running");

  // A passage carved to the right enters the next column
  a_carve_right: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.carved && (out_item_r.direction == DIR_RIGHT))
      |-> ((out_item_r.to_x == 3'(out_item_r.from_x + 3'd1)) &&
           (out_item_r.to_y == out_item_r.from_y)))
    else $error("right passage with inconsistent coordinates");

endmodule

`default_nettype wire

FILE: sv/random_dfs_maze_carver_unit.sv
// Randomized depth-first maze carver. An item is transferred when start is
// high and busy is low; busy stays high until its result is issued. After
// the transfer cycle of a step item the visited map, a one-read-port memory
// of grid rows, delivers the current row, the row above and the row below
// one per cycle, the decision follows, and a backtrack adds the registered
// read of the path stack. After the transfer cycle of a start item the
// visited map is cleared one row per cycle. A step while no maze is running
// is answered without busy going high. Each result is on out_item for
// exactly one cycle with out_valid high, in the cycle after the last cycle
// of its item; the receiver cannot stall it and must take it then.
`default_nettype none

module random_dfs_maze_carver_unit
  import mzc_pkg::*;
#(
  parameter int GRID_COLUMNS = 8,
  parameter int GRID_ROWS    = 6,
  parameter int STACK_DEPTH  = 48
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_item,
  output logic      out_valid,
  output out_t      out_item
);

  cmd_t cmd;
  sts_t sts;

  mzc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_item.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mzc_dp #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: tb/random_dfs_maze_carver_unit_test.sv
module random_dfs_maze_carver_unit_test
  import mzc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS         = 8;
  localparam int ROWS         = 6;
  localparam int CELLS        = COLS * ROWS;
  localparam int DEPTH        = 48;
  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_TAIL    = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PLAN_ROWS    = 16;

  // One row of the directed plan: the item, and a typed report where one is given
  typedef struct packed {
    in_t  item;
    logic typed;
    out_t report;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  // Report that goes with the item currently on in_item
  out_t queued_report;
  out_t pending_reports[$];

  // Carver model state
  logic [CELLS-1:0] seen_cells;
  logic [5:0]       trail [0:DEPTH-1];
  int               walk_x;
  int               walk_y;
  int               trail_len;
  bit               maze_live;

  int mismatches = 0;
  int reports_checked = 0;
  int carves = 0;
  int backtracks = 0;
  int mazes_done = 0;
  int maze_starts = 0;
  int cycles = 0;

  plan_row_t plan [0:PLAN_ROWS-1];

  random_dfs_maze_carver_unit #(
    .GRID_COLUMNS(COLS),
    .GRID_ROWS(ROWS),
    .STACK_DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic plan_row_t plan_row(input logic op, input logic [15:0] rnd,
                                         input logic typed, input out_t report);
    plan_row_t r;
    r.item.op           = op;
    r.item.random_value = rnd;
    r.typed             = typed;
    r.report            = report;
    return r;
  endfunction

  function automatic out_t carve_report(input logic [2:0] fx, input logic [2:0] fy,
                                        input logic [1:0] dir, input logic [2:0] tx,
                                        input logic [2:0] ty);
    out_t r;
    r           = '0;
    r.carved    = 1'b1;
    r.from_x    = fx;
    r.from_y    = fy;
    r.direction = dir;
    r.to_x      = tx;
    r.to_y      = ty;
    return r;
  endfunction

  // Advance the carver model by one item and return the report it gives
  task automatic advance_carver(input in_t item, output out_t report);
    int         cand_x [0:3];
    int         cand_y [0:3];
    logic [1:0] cand_d [0:3];
    int         n;
    int         pick;
    int         cell_idx;
    report = '0;
    n = 0;
    if (item.op == OP_START) begin
      seen_cells    = '0;
      seen_cells[0] = 1'b1;
      walk_x        = 0;
      walk_y        = 0;
      trail_len     = 0;
      maze_live     = 1'b1;
      maze_starts++;
    end else if (maze_live) begin
      // List open neighbors in the order right, left, up, down
      if (walk_x + 1 < COLS && !seen_cells[walk_y * COLS + walk_x + 1]) begin
        cand_x[n] = walk_x + 1; cand_y[n] = walk_y; cand_d[n] = DIR_RIGHT; n++;
      end
      if (walk_x > 0 && !seen_cells[walk_y * COLS + walk_x - 1]) begin
        cand_x[n] = walk_x - 1; cand_y[n] = walk_y; cand_d[n] = DIR_LEFT; n++;
      end
      if (walk_y > 0 && !seen_cells[(walk_y - 1) * COLS + walk_x]) begin
        cand_x[n] = walk_x; cand_y[n] = walk_y - 1; cand_d[n] = DIR_UP; n++;
      end
      if (walk_y + 1 < ROWS && !seen_cells[(walk_y + 1) * COLS + walk_x]) begin
        cand_x[n] = walk_x; cand_y[n] = walk_y + 1; cand_d[n] = DIR_DOWN; n++;
      end
      report.from_x = walk_x[2:0];
      report.from_y = walk_y[2:0];
      if (n > 0) begin
        // Carve into the picked neighbor; saturate the trail when full
        pick = int'(item.random_value) % n;
        if (trail_len < DEPTH) begin
          cell_idx = walk_y * COLS + walk_x;
          trail[trail_len] = cell_idx[5:0];
          trail_len++;
        end
        walk_x = cand_x[pick];
        walk_y = cand_y[pick];
        seen_cells[walk_y * COLS + walk_x] = 1'b1;
        report.carved    = 1'b1;
        report.direction = cand_d[pick];
        carves++;
      end else if (trail_len > 0) begin
        // Dead end: pop back one cell
        trail_len--;
        cell_idx = int'(trail[trail_len]);
        walk_x   = cell_idx % COLS;
        walk_y   = cell_idx / COLS;
        if (walk_y >= ROWS) begin
          walk_y = ROWS - 1;
        end
        backtracks++;
      end else begin
        maze_live       = 1'b0;
        report.done_res = 1'b1;
        mazes_done++;
      end
      report.to_x = walk_x[2:0];
      report.to_y = walk_y[2:0];
    end
  endtask

  // Present one item and hold it until the block takes it
  task automatic send_item(input plan_row_t r);
    out_t report;
    advance_carver(r.item, report);
    if (r.typed) begin
      report = r.report;
    end
    in_item       <= r.item;
    queued_report <= report;
    start         <= 1'b1;
    do begin
      @(posedge clk);
    end while (busy !== 1'b0);
  endtask

  task automatic check_field(input string name, input logic [2:0] want,
                             input logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check results and record each transfer into the block
  always @(posedge clk) begin
    out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("random_dfs_maze_carver_unit test failed");
      $finish;
    end else if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("carved", 3'(want.carved), 3'(out_item.carved));
          check_field("from_x", want.from_x, out_item.from_x);
          check_field("from_y", want.from_y, out_item.from_y);
          check_field("direction", 3'(want.direction), 3'(out_item.direction));
          check_field("to_x", want.to_x, out_item.to_x);
          check_field("to_y", want.to_y, out_item.to_y);
          check_field("done_res", 3'(want.done_res), 3'(out_item.done_res));
          reports_checked++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        pending_reports.push_back(queued_report);
      end
    end
  end

  initial begin
    int        counted;
    int        segment;
    int        last_segment;
    int        gap_pct;
    logic      op;
    logic [15:0] rnd;

    start         = 1'b0;
    in_item       = '0;
    queued_report = '0;
    rst_n         = 1'b0;
    seen_cells    = '0;
    walk_x        = 0;
    walk_y        = 0;
    trail_len     = 0;
    maze_live     = 1'b0;

    // Idle steps, restarts, the two corner picks, then a short dead end
    plan[0]  = plan_row(OP_STEP,  16'h0000, 1'b1, '0);
    plan[1]  = plan_row(OP_STEP,  16'hFFFF, 1'b1, '0);
    plan[2]  = plan_row(OP_START, 16'h0000, 1'b1, '0);
    plan[3]  = plan_row(OP_STEP,  16'h0000, 1'b1,
                        carve_report(3'd0, 3'd0, DIR_RIGHT, 3'd1, 3'd0));
    plan[4]  = plan_row(OP_START, 16'hFFFF, 1'b1, '0);
    plan[5]  = plan_row(OP_STEP,  16'hFFFF, 1'b1,
                        carve_report(3'd0, 3'd0, DIR_DOWN, 3'd0, 3'd1));
    plan[6]  = plan_row(OP_START, 16'h0000, 1'b1, '0);
    plan[7]  = plan_row(OP_STEP,  16'h0000, 1'b1,
                        carve_report(3'd0, 3'd0, DIR_RIGHT, 3'd1, 3'd0));
    plan[8]  = plan_row(OP_STEP,  16'h0001, 1'b1,
                        carve_report(3'd1, 3'd0, DIR_DOWN, 3'd1, 3'd1));
    plan[9]  = plan_row(OP_STEP,  16'h0002, 1'b0, '0);
    plan[10] = plan_row(OP_STEP,  16'h0004, 1'b0, '0);
    plan[11] = plan_row(OP_STEP,  16'h0000, 1'b0, '0);
    plan[12] = plan_row(OP_STEP,  16'h5555, 1'b0, '0);
    plan[13] = plan_row(OP_STEP,  16'hFFFF, 1'b0, '0);
    plan[14] = plan_row(OP_START, 16'hAAAA, 1'b1, '0);
    plan[15] = plan_row(OP_STEP,  16'h8000, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      send_item(plan[i]);
    end

    // Random part: mostly full mazes, with restarts and idle steps as noise
    counted      = 0;
    last_segment = -1;
    gap_pct      = 0;
    while (counted < RANDOM_ITEMS) begin
      segment = counted / 60;
      if (segment != last_segment) begin
        last_segment = segment;
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      end
      if (!maze_live) begin
        op = ($urandom_range(0, 99) < 30) ? OP_STEP : OP_START;
      end else begin
        op = ($urandom_range(0, 199) == 0) ? OP_START : OP_STEP;
      end
      case ($urandom_range(0, 9))
        0:       rnd = 16'h0000;
        1:       rnd = 16'hFFFF;
        default: rnd = 16'($urandom);
      endcase
      if (op == OP_START || maze_live) begin
        counted++;
      end
      send_item(plan_row(op, rnd, 1'b0, '0));
      if (counted < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 99) < gap_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    start <= 1'b0;

    // Drain outstanding reports, then give the block time to misbehave
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d reports over %0d maze starts: %0d carves, %0d backtracks,",
             reports_checked, maze_starts, carves, backtracks);
    $display("%0d mazes carved to completion, idle steps before and after.", mazes_done);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("random_dfs_maze_carver_unit test passed");
    end else begin
      $display("random_dfs_maze_carver_unit test failed");
    end
    $finish;
  end

endmodule

FILE: random_dfs_maze_carver_unit.f
sv/mzc_pkg.sv
sv/mzc_ctrl.sv
sv/mzc_dp.sv
sv/random_dfs_maze_carver_unit.sv
tb/random_dfs_maze_carver_unit_test.sv
